@@ rtl/core/nnfs_pkg.sv @@
package nnfs_pkg;

  localparam int DIM_W    = 12;
  localparam int ACC_W    = 24;
  localparam int PIX_W    = 16;
  localparam int CFG_A_W  = 2;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [DIM_W-1:0] DEF_SRC = DIM_W'(800);
  localparam logic [DIM_W-1:0] DEF_DST = DIM_W'(720);

  typedef enum logic [CFG_A_W-1:0] {
    CFG_SRC_W = 2'd0,
    CFG_SRC_H = 2'd1,
    CFG_DST_W = 2'd2,
    CFG_DST_H = 2'd3
  } nnfs_cfg_idx_t;

  // effective sizes: zero read as one, destination capped at source
  typedef struct packed {
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [DIM_W-1:0] dw;
    logic [DIM_W-1:0] dh;
  } nnfs_size_t;

  typedef struct packed {
    logic             frame_end;
    logic             line_end;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic [PIX_W-1:0] pixel;
  } nnfs_res_t;

endpackage

@@ rtl/core/nnfs_front.sv @@
module nnfs_front
  import nnfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  nnfs_size_t       size,
  input  logic             acc,
  input  logic [PIX_W-1:0] pixel,
  input  logic             frame_start,
  output logic             push,
  output nnfs_res_t        res
);

  logic [DIM_W-1:0] sc_r, sr_r, dc_r, dr_r;
  logic [DIM_W-1:0] sc_nxt, sr_nxt, dc_nxt, dr_nxt;
  logic [ACC_W-1:0] ct_r, cb_r, rt_r, rb_r;
  logic [ACC_W-1:0] ct_nxt, cb_nxt, rt_nxt, rb_nxt;
  logic             rp_r, rp_nxt;

  logic [DIM_W-1:0] sc, sr, dc, dr;
  logic [ACC_W-1:0] ct, cb, rt, rb;
  logic             rp, pick, le, fe, col_wrap, row_wrap;
  logic [DIM_W-1:0] sc_inc, sr_inc;

  always_comb begin
    sc = frame_start ? '0 : sc_r;
    sr = frame_start ? '0 : sr_r;
    dc = frame_start ? '0 : dc_r;
    dr = frame_start ? '0 : dr_r;
    ct = frame_start ? '0 : ct_r;
    cb = frame_start ? '0 : cb_r;
    rt = frame_start ? '0 : rt_r;
    rb = frame_start ? '0 : rb_r;
    rp = frame_start ? 1'b1 : rp_r;

    pick = rp && ({1'b0, ct} < ({1'b0, cb} + (ACC_W+1)'(size.dw)));
    le   = ({1'b0, dc} + (DIM_W+1)'(1)) >= {1'b0, size.dw};
    fe   = le && (({1'b0, dr} + (DIM_W+1)'(1)) >= {1'b0, size.dh});

    ct_nxt = pick ? ct + ACC_W'(size.sw) : ct;
    dc_nxt = pick ? dc + DIM_W'(1) : dc;
    cb_nxt = cb + ACC_W'(size.dw);
    sc_inc = sc + DIM_W'(1);
    sc_nxt = sc_inc;
    sr_nxt = sr;
    dr_nxt = dr;
    rt_nxt = rt;
    rb_nxt = rb;
    rp_nxt = rp;
    sr_inc = sr + DIM_W'(1);
    col_wrap = (sc_inc >= size.sw) || (sc_inc == '0);
    row_wrap = (sr_inc >= size.sh) || (sr_inc == '0);

    if (col_wrap) begin
      sc_nxt = '0;
      dc_nxt = '0;
      ct_nxt = '0;
      cb_nxt = '0;
      rb_nxt = rb + ACC_W'(size.dh);
      sr_nxt = sr_inc;
      if (rp) begin
        rt_nxt = rt + ACC_W'(size.sh);
        dr_nxt = dr + DIM_W'(1);
      end
      if (row_wrap) begin
        sr_nxt = '0;
        dr_nxt = '0;
        rt_nxt = '0;
        rb_nxt = '0;
      end
      rp_nxt = {1'b0, rt_nxt} < ({1'b0, rb_nxt} + (ACC_W+1)'(size.dh));
    end

    push          = acc && pick;
    res.pixel     = pixel;
    res.col       = dc;
    res.row       = dr;
    res.line_end  = le;
    res.frame_end = fe;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= '0;
      sr_r <= '0;
      dc_r <= '0;
      dr_r <= '0;
      ct_r <= '0;
      cb_r <= '0;
      rt_r <= '0;
      rb_r <= '0;
      rp_r <= 1'b1;
    end else if (acc) begin
      sc_r <= sc_nxt;
      sr_r <= sr_nxt;
      dc_r <= dc_nxt;
      dr_r <= dr_nxt;
      ct_r <= ct_nxt;
      cb_r <= cb_nxt;
      rt_r <= rt_nxt;
      rb_r <= rb_nxt;
      rp_r <= rp_nxt;
    end
  end

endmodule

@@ rtl/core/nnfs_queue.sv @@
module nnfs_queue
  import nnfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  nnfs_res_t wr_data,
  output logic      full,
  input  logic      pop,
  output logic      rd_valid,
  output nnfs_res_t rd_data
);

  nnfs_res_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_pop;

  assign full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_pop   = pop && rd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/nearest_neighbor_frame_scaler.sv @@
// Channel  Direction  Ports                  Contents
// in       request in in_tvalid/in_tready    tdata: pixel_value; tuser: frame_start
// out      result out out_tvalid/out_tready  tdata: out_pixel,out_col,out_row;
//                                            tuser: line_end; tlast: frame_end
// cfg      write in   cfg_valid/cfg_ready    cfg_addr: register index; cfg_data
//
// One request per cycle while in_tready is high; the front updates all scan counters in the accept cycle.
// A picked pixel enters the queue in its accept cycle and reaches out once the results ahead of it are taken.
// A 4-entry queue separates front and back; in_tready drops only when it is full.
// Reset is synchronous, active low; a size write applies from the next request on.
module nearest_neighbor_frame_scaler
  import nnfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] pixel_value
  input  logic                  in_tuser,   // [0] frame_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] out_pixel, [27:16] out_col, [39:28] out_row
  output logic                  out_tuser,  // [0] line_end
  output logic                  out_tlast,  // frame_end
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [DIM_W-1:0]      cfg_data
);

  logic [DIM_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  nnfs_size_t       size_eff;
  logic [DIM_W-1:0] dw_eff, dh_eff;
  logic             in_acc, q_full, q_push;
  nnfs_res_t        q_wr, q_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= DEF_SRC;
      src_h_r <= DEF_SRC;
      dst_w_r <= DEF_DST;
      dst_h_r <= DEF_DST;
    end else if (cfg_valid) begin
      unique case (nnfs_cfg_idx_t'(cfg_addr))
        CFG_SRC_W: src_w_r <= cfg_data;
        CFG_SRC_H: src_h_r <= cfg_data;
        CFG_DST_W: dst_w_r <= cfg_data;
        CFG_DST_H: dst_h_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_comb begin
    size_eff.sw = (src_w_r == '0) ? DIM_W'(1) : src_w_r;
    size_eff.sh = (src_h_r == '0) ? DIM_W'(1) : src_h_r;
    dw_eff      = (dst_w_r == '0) ? DIM_W'(1) : dst_w_r;
    dh_eff      = (dst_h_r == '0) ? DIM_W'(1) : dst_h_r;
    size_eff.dw = (dw_eff > size_eff.sw) ? size_eff.sw : dw_eff;
    size_eff.dh = (dh_eff > size_eff.sh) ? size_eff.sh : dh_eff;
  end

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  nnfs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .size        (size_eff),
    .acc         (in_acc),
    .pixel       (in_tdata[PIX_W-1:0]),
    .frame_start (in_tuser),
    .push        (q_push),
    .res         (q_wr)
  );

  nnfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (q_wr),
    .full     (q_full),
    .pop      (out_tready),
    .rd_valid (out_tvalid),
    .rd_data  (q_rd)
  );

  assign out_tdata = {q_rd.row, q_rd.col, q_rd.pixel};
  assign out_tuser = q_rd.line_end;
  assign out_tlast = q_rd.frame_end;

  a_full_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("queue full without a pending result");

  a_frame_end_is_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser)
    else $error("frame end without line end");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

endmodule

@@ verif/nnfs_scan_checker.sv @@
module nnfs_scan_checker
  import nnfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  input  logic                  out_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [DIM_W-1:0]      cfg_data,
  output int                    fail_count,
  output int                    pending
);

  logic [DIM_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
  logic [DIM_W-1:0] src_col, src_row, dst_col, dst_row;
  logic [ACC_W-1:0] col_tgt, col_base, row_tgt, row_base;
  logic             row_sel;
  nnfs_res_t        picked_q[$];
  int               errs;

  initial begin
    errs = 0;
  end

  function automatic logic [DIM_W-1:0] at_least_one(logic [DIM_W-1:0] v);
    return (v == '0) ? DIM_W'(1) : v;
  endfunction

  task automatic clear_scan();
    src_col  = '0;
    src_row  = '0;
    dst_col  = '0;
    dst_row  = '0;
    col_tgt  = '0;
    col_base = '0;
    row_tgt  = '0;
    row_base = '0;
    row_sel  = 1'b1;
  endtask

  // one source pixel through the scan counters; queues the pixel if it is picked
  task automatic track_source_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    logic [DIM_W-1:0] sw, sh, dw, dh;
    nnfs_res_t        r;
    sw = at_least_one(src_w_reg);
    sh = at_least_one(src_h_reg);
    dw = at_least_one(dst_w_reg);
    dh = at_least_one(dst_h_reg);
    if (dw > sw) dw = sw;
    if (dh > sh) dh = sh;
    if (fs) clear_scan();

    if (row_sel && ({1'b0, col_tgt} < ({1'b0, col_base} + (ACC_W+1)'(dw)))) begin
      r.pixel     = pix;
      r.col       = dst_col;
      r.row       = dst_row;
      r.line_end  = ({1'b0, dst_col} + 13'd1) >= {1'b0, dw};
      r.frame_end = r.line_end && (({1'b0, dst_row} + 13'd1) >= {1'b0, dh});
      picked_q.push_back(r);
      col_tgt = col_tgt + ACC_W'(sw);
      dst_col = dst_col + DIM_W'(1);
    end

    col_base = col_base + ACC_W'(dw);
    src_col  = src_col + DIM_W'(1);

    if (src_col >= sw || src_col == '0) begin
      src_col  = '0;
      dst_col  = '0;
      col_tgt  = '0;
      col_base = '0;
      if (row_sel) begin
        row_tgt = row_tgt + ACC_W'(sh);
        dst_row = dst_row + DIM_W'(1);
      end
      row_base = row_base + ACC_W'(dh);
      src_row  = src_row + DIM_W'(1);
      if (src_row >= sh || src_row == '0) begin
        src_row  = '0;
        dst_row  = '0;
        row_tgt  = '0;
        row_base = '0;
      end
      row_sel = {1'b0, row_tgt} < ({1'b0, row_base} + (ACC_W+1)'(dh));
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    nnfs_res_t exp_r;
    if (!rst_n) begin
      src_w_reg = DEF_SRC;
      src_h_reg = DEF_SRC;
      dst_w_reg = DEF_DST;
      dst_h_reg = DEF_DST;
      clear_scan();
      picked_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (picked_q.size() == 0) begin
          $error("unexpected result: pixel %0d col %0d row %0d",
                 out_tdata[15:0], out_tdata[27:16], out_tdata[39:28]);
          errs++;
        end else begin
          exp_r = picked_q.pop_front();
          check_field("out_pixel", 32'(exp_r.pixel), 32'(out_tdata[15:0]));
          check_field("out_col", 32'(exp_r.col), 32'(out_tdata[27:16]));
          check_field("out_row", 32'(exp_r.row), 32'(out_tdata[39:28]));
          check_field("line_end", 32'(exp_r.line_end), 32'(out_tuser));
          check_field("frame_end", 32'(exp_r.frame_end), 32'(out_tlast));
        end
      end
      if (in_tvalid && in_tready)
        track_source_pixel(in_tdata[PIX_W-1:0], in_tuser);
      if (cfg_valid && cfg_ready) begin
        case (nnfs_cfg_idx_t'(cfg_addr))
          CFG_SRC_W: src_w_reg = cfg_data;
          CFG_SRC_H: src_h_reg = cfg_data;
          CFG_DST_W: dst_w_reg = cfg_data;
          CFG_DST_H: dst_h_reg = cfg_data;
          default: ;
        endcase
      end
    end
    pending    <= picked_q.size();
    fail_count <= errs;
  end

endmodule

@@ verif/nearest_neighbor_frame_scaler_tb.sv @@
module nearest_neighbor_frame_scaler_tb;
  import nnfs_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 120;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_A_W-1:0]    cfg_addr;
  logic [DIM_W-1:0]      cfg_data;

  int check_fails;
  int picks_pending;
  int cycles;
  bit gaps_on;
  int hold_req;
  int holds_served;

  nearest_neighbor_frame_scaler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  nnfs_scan_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .fail_count (check_fails),
    .pending    (picks_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(12, 40);
  endfunction

  // result side: random backpressure plus an occasional long hold
  initial begin
    out_tready   = 1'b0;
    holds_served = 0;
    wait (rst_n);
    forever begin
      if (holds_served != hold_req) begin
        holds_served++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 99) < 25) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    in_tdata  <= pix;
    in_tuser  <= fs;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (gaps_on && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (picks_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input nnfs_cfg_idx_t idx, input int val);
    cfg_addr  <= idx;
    cfg_data  <= DIM_W'(val);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_sizes(input int sw, input int sh, input int dw, input int dh);
    put_reg(CFG_SRC_W, sw);
    put_reg(CFG_SRC_H, sh);
    put_reg(CFG_DST_W, dw);
    put_reg(CFG_DST_H, dh);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // raster frames with random pixels; fresh=0 continues the frame in flight, noise=1 gives random frame starts
  task automatic stream_frames(input int n, input int sw, input int sh,
                               input bit fresh, input bit noise);
    int   frame_pix;
    int   pos;
    logic fs;
    frame_pix = ((sw == 0) ? 1 : sw) * ((sh == 0) ? 1 : sh);
    pos = fresh ? 0 : 1;
    for (int k = 0; k < n; k++) begin
      if (noise) begin
        fs = 1'($urandom_range(0, 1));
      end else begin
        fs = (pos == 0) && ($urandom_range(0, 99) < 92);
        if (pos != 0 && $urandom_range(0, 99) < 2) fs = 1'b1;
      end
      if (fs) pos = 0;
      send_pixel(PIX_W'($urandom_range(0, 65535)), fs);
      pos = (pos + 1) % frame_pix;
    end
  endtask

  function automatic int pick_dest(int src);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return (src + 20 > 4095) ? 4095 : src + $urandom_range(1, 20);
    return $urandom_range(1, src);
  endfunction

  initial begin
    int sw, sh, dw, dh;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr  = CFG_SRC_W;
    cfg_data  = '0;
    gaps_on   = 1'b0;
    hold_req  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes, with a long hold on the result side
    gaps_on = 1'b1;
    hold_req++;
    stream_frames(100, 800, 800, 1'b1, 1'b0);
    drain();

    // small frame: pixel extremes, then running past the frame end, then a restart
    gaps_on = 1'b0;
    write_sizes(4, 3, 3, 2);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hAAAA, 1'b0);
    send_pixel(16'h5555, 1'b0);
    for (int k = 0; k < 20; k++)
      send_pixel(PIX_W'($urandom_range(0, 65535)), 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    drain();

    // zero sizes read as one
    write_sizes(0, 0, 0, 0);
    stream_frames(30, 1, 1, 1'b1, 1'b0);
    drain();

    // upscale request saturates to the source size
    gaps_on = 1'b1;
    write_sizes(5, 4, 4095, 4095);
    stream_frames(40, 5, 4, 1'b1, 1'b0);
    drain();

    // largest sizes
    write_sizes(4095, 4095, 4095, 4095);
    stream_frames(150, 4095, 4095, 1'b1, 1'b0);
    drain();
    write_sizes(4095, 4095, 1, 1);
    stream_frames(150, 4095, 4095, 1'b1, 1'b0);
    drain();

    for (int p = 0; p < 12; p++) begin
      sw = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16) : $urandom_range(17, 64);
      sh = $urandom_range(1, 8);
      dw = pick_dest(sw);
      dh = pick_dest(sh);
      write_sizes(sw, sh, dw, dh);
      gaps_on = (p % 3) != 0;
      if (p % 4 == 1) hold_req++;
      stream_frames($urandom_range(40, 100), sw, sh, (p % 5) != 2, p == 11);
      drain();
    end

    if (check_fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
